[sv/eah_pkg.sv]
// shared types, constants and register indexes of the epoch access histogram
`default_nettype none

package eah_pkg;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int VERTEX_W    = 10;
  localparam int EPOCH_OUT_W = 6;
  localparam int EPOCH_CFG_W = 7;
  localparam int CFG_INDEX_W = 2;

  // default sizing
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EPOCHS_DEF   = 64;
  localparam int COUNT_WIDTH_DEF  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HARD_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_COUNT    = CFG_INDEX_W'(1);

  // register reset values
  localparam logic [DATA_W-1:0]      HARD_THRESHOLD_RST = DATA_W'(4096);
  localparam logic [EPOCH_CFG_W-1:0] EPOCH_COUNT_RST    = EPOCH_CFG_W'(20);

  // item function codes
  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  // request item
  typedef struct packed {
    func_t               func;
    logic [VERTEX_W-1:0] vertex;
  } req_t;

  // result item
  typedef struct packed {
    logic [EPOCH_OUT_W-1:0] peak_epoch;
    logic [DATA_W-1:0]      peak_count;
    logic                   found;
  } rsp_t;

  // status of the shared subtract and compare unit
  typedef struct packed {
    logic              gt;
    logic              ge;
    logic [DATA_W-1:0] diff;
  } alu_res_t;

endpackage

`default_nettype wire

[sv/eah_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module eah_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/eah_alu.sv]
// shared subtract and compare unit
`default_nettype none

module eah_alu (
  input  wire logic [eah_pkg::DATA_W-1:0] a,
  input  wire logic [eah_pkg::DATA_W-1:0] b,
  output eah_pkg::alu_res_t               res
);

  logic [eah_pkg::DATA_W:0] sub;

  // one subtractor gives difference, greater-or-equal and greater
  always_comb begin
    sub      = {1'b0, a} - {1'b0, b};
    res.diff = sub[eah_pkg::DATA_W-1:0];
    res.ge   = ~sub[eah_pkg::DATA_W];
    res.gt   = ~sub[eah_pkg::DATA_W] && (sub[eah_pkg::DATA_W-1:0] != '0);
  end

endmodule

`default_nettype wire

[sv/epoch_access_histogram.sv]
// top level: per-epoch access histogram with sequencer over one shared compare unit
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid, req_ready  | req (func, vertex)
//   rsp     | out       | rsp_valid, rsp_ready  | rsp (peak_epoch, peak_count, found)
//   cfg     | in        | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// a record item passes the threshold check, the ram read and, for a vertex in range, the
// read-modify-write before its result is loaded; an epoch advance adds a wrap step of repeated
// subtraction. a query item for a vertex in range reads and compares each epoch in use in turn:
// one read and one compare per epoch, since the single ram port pair and the shared compare unit
// serve every step. the next item can be taken as soon as a result shows. after reset a clearing
// pass zeroes all MAX_EPOCHS * MAX_VERTICES entries; req_ready stays low meanwhile, cfg writes are taken at all times.
// a finished result waits in the output register; the next item is accepted meanwhile.
`default_nettype none

module epoch_access_histogram #(
  parameter int MAX_VERTICES = eah_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EPOCHS   = eah_pkg::MAX_EPOCHS_DEF,
  parameter int COUNT_WIDTH  = eah_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire eah_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output eah_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [eah_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [eah_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_EPOCHS * MAX_VERTICES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (MAX_EPOCHS > 1) ? $clog2(MAX_EPOCHS) : 1;
  localparam int RW    = EW + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TICK,
    S_WRAP,
    S_RREQ,
    S_RMW,
    S_QREQ,
    S_QCMP,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [eah_pkg::DATA_W-1:0]      hard_threshold;
  logic [eah_pkg::EPOCH_CFG_W-1:0] epoch_count;

  // epoch state
  logic [eah_pkg::DATA_W-1:0] access_counter;
  logic [EW-1:0]              epoch_index;
  logic [RW-1:0]              wrap;

  // item and result registers
  logic [eah_pkg::VERTEX_W-1:0]  vertex;
  logic                          vld;
  logic [EW-1:0]                 qe;
  logic [COUNT_WIDTH-1:0]        best_count;
  logic [EW-1:0]                 best_epoch;
  logic                          best_found;
  logic [AW-1:0]                 clr_addr;

  // datapath signals
  logic [eah_pkg::DATA_W-1:0] alu_a;
  logic [eah_pkg::DATA_W-1:0] alu_b;
  eah_pkg::alu_res_t          alu_res;
  logic [eah_pkg::DATA_W-1:0] n32;
  logic [RW-1:0]              n_use;
  logic [EW-1:0]              addr_epoch;
  logic [AW-1:0]              addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [COUNT_WIDTH-1:0]     mem_wdata;
  logic                       mem_re;
  logic [COUNT_WIDTH-1:0]     mem_rdata;
  logic [COUNT_WIDTH-1:0]     sat_inc;
  logic [RW-1:0]              qe_plus;
  logic [eah_pkg::DATA_W-1:0] pe32;
  logic                       req_vld;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // epochs in use, clamped to one and to MAX_EPOCHS
  always_comb begin
    n32 = eah_pkg::DATA_W'(epoch_count);
    if (epoch_count == '0) begin
      n32 = eah_pkg::DATA_W'(1);
    end else if (n32 > eah_pkg::DATA_W'(MAX_EPOCHS)) begin
      n32 = eah_pkg::DATA_W'(MAX_EPOCHS);
    end
  end
  assign n_use = n32[RW-1:0];

  // operand selection for the shared unit
  always_comb begin
    case (state)
      S_TICK: begin
        alu_a = access_counter;
        alu_b = hard_threshold;
      end
      S_WRAP: begin
        alu_a = eah_pkg::DATA_W'(wrap);
        alu_b = eah_pkg::DATA_W'(n_use);
      end
      S_QCMP: begin
        alu_a = eah_pkg::DATA_W'(mem_rdata);
        alu_b = eah_pkg::DATA_W'(best_count);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  eah_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // histogram address: epoch row times vertex count plus vertex
  assign addr_epoch = (state == S_QREQ) ? qe : epoch_index;
  assign addr       = AW'(AW'(addr_epoch) * AW'(MAX_VERTICES)) + AW'(vertex);

  // ram port control
  assign sat_inc   = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
  assign mem_we    = (state == S_CLEAR) || (state == S_RMW);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : sat_inc;
  assign mem_re    = (state == S_RREQ) || (state == S_QREQ);

  eah_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  assign qe_plus = RW'(qe) + RW'(1);
  assign pe32    = eah_pkg::DATA_W'(best_epoch);
  assign req_vld = eah_pkg::DATA_W'(req.vertex) < eah_pkg::DATA_W'(MAX_VERTICES);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_threshold <= eah_pkg::HARD_THRESHOLD_RST;
      epoch_count    <= eah_pkg::EPOCH_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        eah_pkg::REG_HARD_THRESHOLD: hard_threshold <= cfg_data;
        eah_pkg::REG_EPOCH_COUNT:    epoch_count    <= cfg_data[eah_pkg::EPOCH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      access_counter <= '0;
      epoch_index    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // taken result leaves unless a new one is loaded in the same cycle
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        // zero the histogram one entry a cycle
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            vertex     <= req.vertex;
            vld        <= req_vld;
            qe         <= '0;
            best_count <= '0;
            best_epoch <= '0;
            best_found <= 1'b0;
            if (req.func == eah_pkg::FUNC_RECORD) begin
              state <= S_TICK;
            end else if (req_vld) begin
              state <= S_QREQ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // access counter against the hard threshold
        S_TICK: begin
          if (alu_res.gt) begin
            access_counter <= '0;
            wrap           <= RW'(epoch_index) + RW'(1);
            state          <= S_WRAP;
          end else begin
            access_counter <= access_counter + eah_pkg::DATA_W'(1);
            state          <= S_RREQ;
          end
        end
        // wrap the epoch index by repeated subtraction
        S_WRAP: begin
          if (alu_res.ge) begin
            wrap <= alu_res.diff[RW-1:0];
          end else begin
            epoch_index <= wrap[EW-1:0];
            state       <= S_RREQ;
          end
        end
        S_RREQ: begin
          best_epoch <= epoch_index;
          state      <= vld ? S_RMW : S_DONE;
        end
        // saturating increment written back
        S_RMW: begin
          best_count <= sat_inc;
          best_found <= 1'b1;
          state      <= S_DONE;
        end
        S_QREQ: begin
          state <= S_QCMP;
        end
        // keep the first strictly greatest count
        S_QCMP: begin
          if (alu_res.gt) begin
            best_count <= mem_rdata;
            best_epoch <= qe;
            best_found <= 1'b1;
          end
          if (qe_plus == n_use) begin
            state <= S_DONE;
          end else begin
            qe    <= qe_plus[EW-1:0];
            state <= S_QREQ;
          end
        end
        // hand the result to the output register once it is free
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.peak_epoch <= pe32[eah_pkg::EPOCH_OUT_W-1:0];
            rsp.peak_count <= eah_pkg::DATA_W'(best_count);
            rsp.found      <= best_found;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/eah_checker.sv]
// port level checks of the epoch access histogram and their binding
`default_nettype none

module eah_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire eah_pkg::req_t                   req,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire eah_pkg::rsp_t                   rsp,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [eah_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [eah_pkg::DATA_W-1:0]      cfg_data
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // the clearing pass follows reset, so no item is taken right after it
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item taken during the clearing pass");

  // one item at a time: busy in the cycle after an accepted item
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

  // found is set exactly when the reported count is nonzero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.found == (rsp.peak_count != '0)))
    else $error("found flag disagrees with peak count");

endmodule

bind epoch_access_histogram eah_checker u_eah_checker (.*);

`default_nettype wire
